// ----- src/wisp_pkg.sv -----
`default_nettype none
package wisp_pkg;

  // One input word: a blob byte and its end marker.
  typedef struct packed {
    logic [7:0] ie_byte;
    logic       blob_end;
  } item_t;

  // One result word: the security summary of a finished blob.
  typedef struct packed {
    logic [1:0] auth_mode;
    logic       rsn_found;
    logic       sae_found;
    logic       wpa_found;
  } result_t;

  // Parser position within the current element.
  typedef enum logic [1:0] {
    PH_TAG  = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  // Authentication codes reported on the result port.
  typedef enum logic [1:0] {
    AUTH_OPEN = 2'd0,
    AUTH_WPA2 = 2'd1,
    AUTH_WPA3 = 2'd2
  } auth_t;

  // Element tags and matched byte patterns.
  localparam logic [7:0]  TAG_RSN    = 8'h30;
  localparam logic [7:0]  TAG_VENDOR = 8'hDD;
  localparam logic [31:0] SUITE_SAE  = {8'h00, 8'h0F, 8'hAC, 8'h08};
  localparam logic [31:0] VENDOR_WPA = {8'h00, 8'h50, 8'hF2, 8'h01};

  // Flag bits kept per element and per blob.
  localparam logic [2:0] FLAG_RSN = 3'b001;
  localparam logic [2:0] FLAG_SAE = 3'b010;
  localparam logic [2:0] FLAG_WPA = 3'b100;

endpackage
`default_nettype wire

// ----- src/wifi_ie_security_parser_core.sv -----
`default_nettype none
// Streaming 802.11 information-element security parser. Each input word carries one byte of
// an element blob and a flag that marks the blob's final byte; one word is accepted every
// cycle while the result side keeps up. A byte is captured in an input register and parsed
// from there against the tag/length/body state, and on the final byte the RSN, SAE and WPA
// flags and the auth code are loaded into the result register behind the input register.
// Only elements whose body ends inside the blob contribute flags. The parser state returns
// to its reset values after each final byte.
// A final byte waits in the input register only while an earlier result is still untaken.
module wifi_ie_security_parser_core (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     item_valid,
  output logic                    item_ready,
  input  wire wisp_pkg::item_t    item,
  output logic                    result_valid,
  input  wire                     result_ready,
  output wisp_pkg::result_t       result
);

  // Input register.
  logic            s1_valid;
  wisp_pkg::item_t s1_item;
  logic            advance;

  // Parser state.
  wisp_pkg::phase_t phase, phase_next;
  logic [7:0]       cur_tag, cur_tag_next;
  logic [7:0]       cur_len, cur_len_next;
  logic [7:0]       body_off, body_off_next;
  logic [15:0]      pw_count, pw_count_next;
  logic [15:0]      akm_count, akm_count_next;
  logic [23:0]      recent, recent_next;
  logic [2:0]       elem_flags, elem_flags_next;
  logic [2:0]       comm_flags, comm_flags_next;

  // Parse helpers.
  logic [7:0]        b;
  logic [31:0]       word;
  logic [18:0]       off_ext;
  logic [18:0]       akm_at;
  logic [18:0]       diff;
  logic [2:0]        flags_tmp;
  wisp_pkg::result_t result_next;

  // The input word moves on unless it is a final byte and the result register is full and not being taken.
  assign advance    = s1_valid && (!s1_item.blob_end || !result_valid || result_ready);
  assign item_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
    if (item_ready && item_valid) begin
      s1_item <= item;
    end
  end

  // Next parser state for the word in the input register.
  assign b       = s1_item.ie_byte;
  assign word    = {recent, b};
  assign off_ext = {11'd0, body_off};
  assign akm_at  = 19'd6 + {1'b0, pw_count, 2'b00};
  assign diff    = off_ext - akm_at - 19'd2;

  always_comb begin
    phase_next      = phase;
    cur_tag_next    = cur_tag;
    cur_len_next    = cur_len;
    body_off_next   = body_off;
    pw_count_next   = pw_count;
    akm_count_next  = akm_count;
    recent_next     = recent;
    elem_flags_next = elem_flags;
    comm_flags_next = comm_flags;
    flags_tmp       = elem_flags;
    unique case (phase)
      wisp_pkg::PH_LEN: begin
        cur_len_next    = b;
        body_off_next   = 8'd0;
        pw_count_next   = 16'd0;
        akm_count_next  = 16'd0;
        recent_next     = 24'd0;
        elem_flags_next = (cur_tag == wisp_pkg::TAG_RSN && b >= 8'd2) ?
                          wisp_pkg::FLAG_RSN : 3'b000;
        if (b == 8'd0) begin
          // An empty element completes at once and marks nothing.
          elem_flags_next = 3'b000;
          phase_next      = wisp_pkg::PH_TAG;
        end else begin
          phase_next = wisp_pkg::PH_BODY;
        end
      end
      wisp_pkg::PH_BODY: begin
        if (cur_tag == wisp_pkg::TAG_RSN) begin
          if (body_off == 8'd4) begin
            pw_count_next = {pw_count[15:8], b};
          end else if (body_off == 8'd5) begin
            pw_count_next = {b, pw_count[7:0]};
          end else if (body_off >= 8'd6) begin
            if (off_ext == akm_at) begin
              akm_count_next = {akm_count[15:8], b};
            end else if (off_ext == akm_at + 19'd1) begin
              akm_count_next = {b, akm_count[7:0]};
            end else if (off_ext >= akm_at + 19'd5 && diff[1:0] == 2'b11) begin
              // Last byte of an AKM suite: compare it if it is within the count.
              if ({1'b0, diff[18:2]} < {2'b00, akm_count} && word == wisp_pkg::SUITE_SAE) begin
                flags_tmp = flags_tmp | wisp_pkg::FLAG_SAE;
              end
            end
          end
        end else if (cur_tag == wisp_pkg::TAG_VENDOR) begin
          if (body_off == 8'd3 && word == wisp_pkg::VENDOR_WPA) begin
            flags_tmp = flags_tmp | wisp_pkg::FLAG_WPA;
          end
        end
        recent_next = word[23:0];
        if ({1'b0, body_off} + 9'd1 >= {1'b0, cur_len}) begin
          // Body complete: the element's flags now count.
          comm_flags_next = comm_flags | flags_tmp;
          elem_flags_next = 3'b000;
          phase_next      = wisp_pkg::PH_TAG;
        end else begin
          elem_flags_next = flags_tmp;
          body_off_next   = body_off + 8'd1;
        end
      end
      default: begin
        // Expecting a tag byte.
        cur_tag_next = b;
        phase_next   = wisp_pkg::PH_LEN;
      end
    endcase

    // Summary of the blob as of this byte.
    result_next.rsn_found = comm_flags_next[0];
    result_next.sae_found = comm_flags_next[1];
    result_next.wpa_found = comm_flags_next[2];
    if (comm_flags_next[1]) begin
      result_next.auth_mode = wisp_pkg::AUTH_WPA3;
    end else if (comm_flags_next[0] || comm_flags_next[2]) begin
      result_next.auth_mode = wisp_pkg::AUTH_WPA2;
    end else begin
      result_next.auth_mode = wisp_pkg::AUTH_OPEN;
    end

    // The final byte returns the parser to its reset state.
    if (s1_item.blob_end) begin
      phase_next      = wisp_pkg::PH_TAG;
      cur_tag_next    = 8'd0;
      cur_len_next    = 8'd0;
      body_off_next   = 8'd0;
      pw_count_next   = 16'd0;
      akm_count_next  = 16'd0;
      recent_next     = 24'd0;
      elem_flags_next = 3'b000;
      comm_flags_next = 3'b000;
    end
  end

  // Parser state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= wisp_pkg::PH_TAG;
      cur_tag    <= 8'd0;
      cur_len    <= 8'd0;
      body_off   <= 8'd0;
      pw_count   <= 16'd0;
      akm_count  <= 16'd0;
      recent     <= 24'd0;
      elem_flags <= 3'b000;
      comm_flags <= 3'b000;
    end else if (advance) begin
      phase      <= phase_next;
      cur_tag    <= cur_tag_next;
      cur_len    <= cur_len_next;
      body_off   <= body_off_next;
      pw_count   <= pw_count_next;
      akm_count  <= akm_count_next;
      recent     <= recent_next;
      elem_flags <= elem_flags_next;
      comm_flags <= comm_flags_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && s1_item.blob_end) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (advance && s1_item.blob_end) begin
      result <= result_next;
    end
  end

  // SAE is only ever found inside an RSN element and always reports WPA3.
  a_sae_implies_rsn: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.sae_found |->
      result.rsn_found && result.auth_mode == wisp_pkg::AUTH_WPA3)
    else $error("SAE reported without RSN or WPA3");

  // An open result carries no security flags.
  a_open_no_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.auth_mode == wisp_pkg::AUTH_OPEN |->
      !result.rsn_found && !result.wpa_found && !result.sae_found)
    else $error("open auth with flags set");

  // A final byte leaves the parser in its reset state.
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    advance && s1_item.blob_end |=>
      phase == wisp_pkg::PH_TAG && comm_flags == 3'b000 && elem_flags == 3'b000)
    else $error("parser state not cleared after final byte");

  // A word held in the input register stays put until it moves on.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_item))
    else $error("input register changed while stalled");

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;

  typedef logic [7:0] octet_q[$];

  localparam int TOTAL_BYTES = 1750;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  wisp_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  wisp_pkg::result_t result;

  // Expected blob summaries, oldest first.
  wisp_pkg::result_t pending_summaries[$];
  int      mismatches = 0;
  int      bytes_sent = 0;
  int      cycle_count = 0;
  bit      send_idle = 1'b0;
  bit      recv_idle = 1'b0;

  // Blob under construction by the element builders.
  octet_q  blob;

  // Shadow copy of the parser state.
  wisp_pkg::phase_t phase;
  logic [7:0]  el_tag;
  logic [7:0]  el_len;
  logic [7:0]  body_pos;
  logic [15:0] pw_count;
  logic [15:0] akm_count;
  logic [23:0] tail;
  logic [2:0]  el_flags;
  logic [2:0]  blob_flags;

  wifi_ie_security_parser_core uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_parser();
    phase = wisp_pkg::PH_TAG;
    el_tag = '0;
    el_len = '0;
    body_pos = '0;
    pw_count = '0;
    akm_count = '0;
    tail = '0;
    el_flags = '0;
    blob_flags = '0;
  endfunction

  // An element's flags count only once its body has ended.
  function automatic void close_element();
    blob_flags = blob_flags | el_flags;
    el_flags = '0;
    phase = wisp_pkg::PH_TAG;
  endfunction

  // Advances the shadow parser by one byte; returns 1 when a summary is due.
  function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                    output wisp_pkg::result_t summary);
    logic [31:0] window;
    int unsigned off;
    int unsigned akm_at;
    int unsigned idx;
    summary = '0;
    case (phase)
      wisp_pkg::PH_LEN: begin
        el_len = b;
        body_pos = '0;
        pw_count = '0;
        akm_count = '0;
        tail = '0;
        el_flags = '0;
        if (el_tag == wisp_pkg::TAG_RSN && b >= 8'd2) el_flags = wisp_pkg::FLAG_RSN;
        if (b == 8'd0) close_element();
        else phase = wisp_pkg::PH_BODY;
      end
      wisp_pkg::PH_BODY: begin
        off = body_pos;
        window = {tail, b};
        akm_at = 6 + 4 * int'(pw_count);
        if (el_tag == wisp_pkg::TAG_RSN) begin
          // Pairwise count at offsets 4 and 5, then the AKM count and its suites.
          if (off == 4) pw_count[7:0] = b;
          else if (off == 5) pw_count[15:8] = b;
          else if (off >= 6) begin
            if (off == akm_at) akm_count[7:0] = b;
            else if (off == akm_at + 1) akm_count[15:8] = b;
            else if (off >= akm_at + 5 && ((off - akm_at - 2) & 3) == 3) begin
              idx = (off - akm_at - 2) >> 2;
              if (idx < akm_count && window == wisp_pkg::SUITE_SAE)
                el_flags = el_flags | wisp_pkg::FLAG_SAE;
            end
          end
        end else if (el_tag == wisp_pkg::TAG_VENDOR) begin
          if (off == 3 && window == wisp_pkg::VENDOR_WPA)
            el_flags = el_flags | wisp_pkg::FLAG_WPA;
        end
        tail = window[23:0];
        if (off + 1 >= el_len) close_element();
        else body_pos = 8'(off + 1);
      end
      default: begin
        el_tag = b;
        phase = wisp_pkg::PH_LEN;
      end
    endcase
    if (!last) return 1'b0;
    if ((blob_flags & wisp_pkg::FLAG_SAE) != 0)
      summary.auth_mode = wisp_pkg::AUTH_WPA3;
    else if ((blob_flags & (wisp_pkg::FLAG_RSN | wisp_pkg::FLAG_WPA)) != 0)
      summary.auth_mode = wisp_pkg::AUTH_WPA2;
    else
      summary.auth_mode = wisp_pkg::AUTH_OPEN;
    summary.rsn_found = (blob_flags & wisp_pkg::FLAG_RSN) != 0;
    summary.sae_found = (blob_flags & wisp_pkg::FLAG_SAE) != 0;
    summary.wpa_found = (blob_flags & wisp_pkg::FLAG_WPA) != 0;
    clear_parser();
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [1:0] exp_v, logic [1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Predict on every accepted input word and check every accepted result word.
  always @(posedge clk) begin
    wisp_pkg::result_t predicted;
    wisp_pkg::result_t oldest;
    if (!rst) begin
      if (item_valid && item_ready) begin
        if (parse_byte(item.ie_byte, item.blob_end, predicted))
          pending_summaries.push_back(predicted);
      end
      if (result_valid && result_ready) begin
        if (pending_summaries.size() == 0) begin
          $display("%0t: unexpected result word, expected none actual %b", $time, result);
          mismatches++;
        end else begin
          oldest = pending_summaries.pop_front();
          check_field("auth_mode", oldest.auth_mode, result.auth_mode);
          check_field("rsn_found", 2'(oldest.rsn_found), 2'(result.rsn_found));
          check_field("sae_found", 2'(oldest.sae_found), 2'(result.sae_found));
          check_field("wpa_found", 2'(oldest.wpa_found), 2'(result.wpa_found));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: a random stall before each result word.
  initial begin
    int stall;
    repeat (6) @(posedge clk);
    forever begin
      stall = (recv_idle && $urandom_range(0, 2) != 0) ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  // Sends one word and returns at the edge that accepts it.
  task automatic send_word(input logic [7:0] b, input logic last);
    int gap;
    gap = (send_idle && $urandom_range(0, 2) != 0) ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= '{ie_byte: b, blob_end: last};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_blob();
    for (int i = 0; i < blob.size(); i++) send_word(blob[i], i == blob.size() - 1);
    blob.delete();
  endtask

  // Holds off the sender until every expected summary has arrived.
  task automatic wait_summaries_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_summaries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Appends an RSN element with its pairwise count at body offset four, where the parser
  // reads it; counts may disagree with the suites actually present.
  task automatic add_rsn(input int pw_n, input int pw_claim, input int akm_n,
                         input int akm_claim, input int sae_at, input int extra,
                         input int len_adj);
    octet_q body;
    int blen;
    body = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'h00, 8'h0F};
    body.push_back(pw_claim[7:0]);
    body.push_back(pw_claim[15:8]);
    repeat (pw_n) body = {body, 8'h00, 8'h0F, 8'hAC, 8'($urandom_range(0, 255))};
    body.push_back(akm_claim[7:0]);
    body.push_back(akm_claim[15:8]);
    for (int i = 0; i < akm_n; i++) begin
      if (i == sae_at)
        body = {body, wisp_pkg::SUITE_SAE[31:24], wisp_pkg::SUITE_SAE[23:16],
                wisp_pkg::SUITE_SAE[15:8], wisp_pkg::SUITE_SAE[7:0]};
      else if ($urandom_range(0, 3) == 0)
        body = {body, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
      else
        body = {body, 8'h00, 8'h0F, 8'hAC, 8'($urandom_range(0, 9))};
    end
    repeat (extra) body.push_back(8'($urandom_range(0, 255)));
    blen = body.size() + len_adj;
    if (blen < 0) blen = 0;
    if (blen > 255) blen = 255;
    blob.push_back(wisp_pkg::TAG_RSN);
    blob.push_back(blen[7:0]);
    blob = {blob, body};
  endtask

  // Appends a vendor element, either the WPA pattern or a near miss of it.
  task automatic add_vendor(input bit wpa, input int extra, input int len_adj);
    octet_q body;
    int blen;
    int pick;
    body = {wisp_pkg::VENDOR_WPA[31:24], wisp_pkg::VENDOR_WPA[23:16],
            wisp_pkg::VENDOR_WPA[15:8], wisp_pkg::VENDOR_WPA[7:0]};
    if (!wpa) begin
      pick = $urandom_range(0, 3);
      body[pick] = body[pick] ^ 8'($urandom_range(1, 255));
    end
    repeat (extra) body.push_back(8'($urandom_range(0, 255)));
    blen = body.size() + len_adj;
    if (blen < 0) blen = 0;
    blob.push_back(wisp_pkg::TAG_VENDOR);
    blob.push_back(blen[7:0]);
    blob = {blob, body};
  endtask

  task automatic add_other();
    int blen;
    blen = $urandom_range(0, 10);
    blob.push_back(8'($urandom_range(0, 255)));
    blob.push_back(blen[7:0]);
    repeat (blen) blob.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_random_rsn();
    int pw_n;
    int akm_n;
    int pw_claim;
    int akm_claim;
    int sae_at;
    int len_adj;
    pw_n = $urandom_range(0, 2);
    akm_n = $urandom_range(0, 3);
    pw_claim = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : pw_n;
    akm_claim = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : akm_n;
    if ($urandom_range(0, 5) == 0) akm_claim = $urandom_range(0, akm_n);
    sae_at = ($urandom_range(0, 2) != 0) ? $urandom_range(0, 3) : -1;
    len_adj = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 6)) - 4 : 0;
    add_rsn(pw_n, pw_claim, akm_n, akm_claim, sae_at, $urandom_range(0, 3), len_adj);
  endtask

  // Blobs of a single byte, the lowest and highest byte values.
  task automatic test_lone_tag();
    blob = {8'h00};
    send_blob();
    blob = {8'hFF};
    send_blob();
  endtask

  // Zero-length elements complete on their length byte and mark nothing.
  task automatic test_zero_length();
    blob = {wisp_pkg::TAG_VENDOR, 8'h00};
    send_blob();
    blob = {wisp_pkg::TAG_RSN, 8'h00};
    send_blob();
  endtask

  // RSN marks at length two but not at length one.
  task automatic test_rsn_length();
    blob = {wisp_pkg::TAG_RSN, 8'h02, 8'hFF, 8'hFF};
    send_blob();
    blob = {wisp_pkg::TAG_RSN, 8'h01, 8'h55};
    send_blob();
  endtask

  // A blob that ends inside a body drops that element.
  task automatic test_truncation();
    blob = {wisp_pkg::TAG_RSN, 8'h05, 8'h01};
    send_blob();
    blob = {wisp_pkg::TAG_VENDOR, 8'h04};
    send_blob();
  endtask

  task automatic test_wpa_vendor();
    add_vendor(1'b1, 0, 0);
    send_blob();
    add_vendor(1'b0, 0, 0);
    send_blob();
  endtask

  // SAE in range, beyond the AKM count, cut off by the length, and behind a bad pairwise count.
  task automatic test_sae_suites();
    add_rsn(0, 0, 1, 1, 0, 0, 0);
    send_blob();
    add_rsn(0, 0, 2, 1, 1, 0, 0);
    send_blob();
    add_rsn(0, 0, 1, 1, 0, 0, -1);
    send_blob();
    add_rsn(0, 300, 1, 1, 0, 0, 0);
    add_vendor(1'b1, 1, 0);
    send_blob();
  endtask

  // Mostly well-formed element lists, with some truncated blobs and raw noise.
  task automatic test_random_blobs();
    int kind;
    while (bytes_sent < TOTAL_BYTES) begin
      send_idle = $urandom_range(0, 3) != 0;
      recv_idle = $urandom_range(0, 3) != 0;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 12)) blob.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 4))
            0, 1: add_random_rsn();
            2: add_vendor($urandom_range(0, 2) != 0, $urandom_range(0, 4),
                          ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 5)) - 4 : 0);
            3: add_other();
            default: begin
              add_random_rsn();
              add_vendor(1'b1, $urandom_range(0, 2), 0);
            end
          endcase
        end
        if (kind == 1) blob = blob[0:$urandom_range(0, blob.size() - 1)];
      end
      send_blob();
      if ($urandom_range(0, 49) == 0) wait_summaries_drained();
    end
  endtask

  // The sender stops until the result side has caught up, then resumes.
  task automatic test_drain_pause();
    send_idle = 1'b0;
    recv_idle = 1'b1;
    repeat (3) begin
      add_random_rsn();
      send_blob();
    end
    wait_summaries_drained();
    add_vendor(1'b1, 0, 0);
    send_blob();
  endtask

  initial begin
    clear_parser();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_lone_tag();
    test_zero_length();
    test_rsn_length();
    test_truncation();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    test_wpa_vendor();
    test_sae_suites();
    test_drain_pause();
    test_random_blobs();
    wait_summaries_drained();
    if (mismatches == 0 && pending_summaries.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/wisp_pkg.sv
src/wifi_ie_security_parser_core.sv
tb/sv/tb.sv
